/* hdl/wve_pkg.sv */
// Shared types, register numbers and arithmetic helpers for the wavetable voice engine.
// Used by the engine top level and the bench; depends on nothing.
package wve_pkg;

   // Kinds of request carried by an input item.
   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_STEP  = 2'd2,
      REQ_FETCH = 2'd3
   } req_kind_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_REG_A,
      ST_REG_B,
      ST_INTERP0,
      ST_INTERP1,
      ST_LP1_MUL,
      ST_LP1_ADD,
      ST_LP2_MUL,
      ST_LP2_ADD,
      ST_P3_MUL,
      ST_P3_ADD,
      ST_P4_MUL,
      ST_P4_ADD,
      ST_VOL_L,
      ST_VOL_R,
      ST_ADVANCE,
      ST_LOOP_CHK,
      ST_LOOP_FIX,
      ST_FIN
   } state_type;

   // Register numbers within a page.
   localparam logic [3:0] REG_CTRL   = 4'd0;
   localparam logic [3:0] REG_STEP   = 4'd1;
   localparam logic [3:0] REG_LS_HI  = 4'd2;
   localparam logic [3:0] REG_LS_LO  = 4'd3;
   localparam logic [3:0] REG_LE_HI  = 4'd4;
   localparam logic [3:0] REG_LE_LO  = 4'd5;
   localparam logic [3:0] REG_K2     = 4'd6;
   localparam logic [3:0] REG_K1     = 4'd7;
   localparam logic [3:0] REG_PAN_L  = 4'd8;
   localparam logic [3:0] REG_PAN_R  = 4'd9;
   localparam logic [3:0] REG_POS_HI = 4'd10;
   localparam logic [3:0] REG_POS_LO = 4'd11;
   localparam logic [3:0] REG_ACTIVE = 4'd13;
   localparam logic [3:0] REG_IRQV   = 4'd14;
   localparam logic [3:0] REG_PAGE   = 4'd15;
   localparam logic [3:0] REG_MODE   = 4'd8;
   localparam logic [3:0] REG_PORT   = 4'd9;

   // Pole slots within a voice's group of six.
   localparam logic [2:0] PS_P1  = 3'd0;
   localparam logic [2:0] PS_P2  = 3'd1;
   localparam logic [2:0] PS_P2Q = 3'd2;
   localparam logic [2:0] PS_P3  = 3'd3;
   localparam logic [2:0] PS_P3Q = 3'd4;
   localparam logic [2:0] PS_P4  = 3'd5;

   localparam logic [15:0] IRQ_IDLE = 16'h0080;

   // Pole slot that a pole-page register number maps to.
   function automatic logic [2:0] pole_slot(input logic [3:0] r);
      case (r)
         REG_STEP:  return PS_P4;
         REG_LS_HI: return PS_P3;
         REG_LS_LO: return PS_P3Q;
         REG_LE_HI: return PS_P2;
         REG_LE_LO: return PS_P2Q;
         default:   return PS_P1;
      endcase
   endfunction

   // Exponential volume: mantissa with hidden one, shifted by the exponent.
   function automatic logic [15:0] vol_of(input logic [7:0] v);
      logic [15:0] m;
      logic [4:0]  sh;
      m  = {1'b1, v[3:0], 11'd0};
      sh = 5'd16 - {1'b0, v[7:4]};
      return m >> sh;
   endfunction

   // Signed division by 4096, truncating toward zero.
   function automatic logic [31:0] div_4096(input logic [31:0] p);
      logic [31:0] t;
      t = p + (p[31] ? 32'd4095 : 32'd0);
      return 32'($signed(t) >>> 12);
   endfunction

   // Signed division by 8192, truncating toward zero.
   function automatic logic [31:0] div_8192(input logic [31:0] p);
      logic [31:0] t;
      t = p + (p[31] ? 32'd8191 : 32'd0);
      return 32'($signed(t) >>> 13);
   endfunction

   // Signed halving, truncating toward zero.
   function automatic logic [31:0] half(input logic [31:0] p);
      logic [31:0] t;
      t = p + {31'd0, p[31]};
      return 32'($signed(t) >>> 1);
   endfunction

endpackage

/* hdl/wve_req_if.sv */
// Request channel of the wavetable voice engine: valid/ready and one request item.
// Stand-alone; no package needed.
interface wve_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [3:0]         reg_req;
   logic [15:0]        write_value;
   logic signed [15:0] first_sample;
   logic signed [15:0] second_sample;
   logic [9:0]         port_pins;

   modport source(output valid, req_type, reg_req, write_value, first_sample,
                  second_sample, port_pins, input ready);
   modport sink(input valid, req_type, reg_req, write_value, first_sample,
                second_sample, port_pins, output ready);
endinterface

/* hdl/wve_rsp_if.sv */
// Response channel of the wavetable voice engine: valid/ready and one result item.
// Stand-alone; no package needed.
interface wve_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        read_data;
   logic [4:0]         voice_index;
   logic [1:0]         bus;
   logic signed [31:0] left_part;
   logic signed [31:0] right_part;
   logic [19:0]        fetch_address;
   logic               fetch_bank;
   logic               voice_stopped;
   logic               frame_end;
   logic               irq_pending;

   modport source(output valid, read_data, voice_index, bus, left_part, right_part,
                  fetch_address, fetch_bank, voice_stopped, frame_end, irq_pending,
                  input ready);
   modport sink(input valid, read_data, voice_index, bus, left_part, right_part,
                fetch_address, fetch_bank, voice_stopped, frame_end, irq_pending,
                output ready);
endinterface

/* hdl/wavetable_voice_engine.sv */
// Top level of the wavetable voice engine: paged voice registers and voice datapath.
// Depends on wve_pkg, wve_req_if, wve_rsp_if and wve_ram.
//
//   channel   direction   handshake      item
//   req_if    in          valid/ready    read, write, voice step or fetch query
//   rsp_if    out         valid/ready    read data, voice contributions, fetch address
//
// A register read, write or fetch query runs states REG_A and REG_B; a voice step on a
// playing voice runs INTERP0 to LOOP_FIX, on a stopped voice only INTERP0, all set by
// the sequencer around a shared 32x16 multiplier and the registered pole RAM read port.
// Synchronous active-high reset restores all voice registers; pole RAM entries read as
// zero until written, tracked by one valid bit per entry.
// A new item is taken while a result waits in the output register; the final cycle of
// an item waits for that register to be free.
module wavetable_voice_engine #(
   parameter int VOICES    = 32,
   parameter int BUS_PAIRS = 4
) (
   input logic          clock,
   input logic          reset,
   wve_req_if.sink      req_if,
   wve_rsp_if.source    rsp_if
);
   localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int POLES = VOICES * 6;
   localparam int PAW   = (POLES > 1) ? $clog2(POLES) : 1;
   localparam logic [5:0] NV = 6'(VOICES);

   // Per-voice register arrays.
   logic [11:0] ctrl_ff [VOICES];
   logic [16:0] step_ff [VOICES];
   logic [30:0] ls_ff   [VOICES];
   logic [30:0] le_ff   [VOICES];
   logic [30:0] pos_ff  [VOICES];
   logic [11:0] k1_ff   [VOICES];
   logic [11:0] k2_ff   [VOICES];
   logic [7:0]  pl_ff   [VOICES];
   logic [7:0]  pr_ff   [VOICES];

   // Global registers.
   logic [4:0] active_ff, active_in;
   logic       irq_pend_ff, irq_pend_in;
   logic [4:0] irqv_ff, irqv_in;
   logic [6:0] page_ff, page_in;
   logic [7:0] mode_ff, mode_in;
   logic [4:0] turn_ff, turn_in;

   // Sequencer and working registers.
   wve_pkg::state_type state_ff, state_in;
   logic [1:0]  rq_type_ff, rq_type_in;
   logic [3:0]  rq_reg_ff, rq_reg_in;
   logic [15:0] rq_wv_ff, rq_wv_in;
   logic [15:0] smp0_ff, smp0_in;
   logic [15:0] smp1_ff, smp1_in;
   logic [9:0]  pins_ff, pins_in;
   logic [4:0]  cur_vi_ff, cur_vi_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] st0_ff, st0_in;
   logic [31:0] st1_ff, st1_in;
   logic [31:0] st3_ff, st3_in;
   logic [31:0] st5_ff, st5_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] right_ff, right_in;
   logic [30:0] a_ff, a_in;
   logic [30:0] d_ff, d_in;
   logic        exceed_ff, exceed_in;
   logic        stop_ff, stop_in;
   logic        fend_ff, fend_in;
   logic [1:0]  bus_ff, bus_in;
   logic [15:0] rd_ff, rd_in;

   // Response register.
   logic        rsp_valid_ff;
   logic [15:0] o_rd_ff;
   logic [4:0]  o_vi_ff;
   logic [1:0]  o_bus_ff;
   logic [31:0] o_left_ff, o_right_ff;
   logic [19:0] o_fa_ff;
   logic        o_fb_ff, o_stop_ff, o_fend_ff, o_irq_ff;

   // Pole valid bits and RAM port.
   logic [POLES-1:0] pv_ff;
   logic             pvq_ff;
   logic             ram_we;
   logic [PAW-1:0]   ram_waddr, ram_raddr;
   logic [31:0]      ram_wdata, ram_q, pole_rd;

   // Array write strobes.
   logic        ctrl_we, step_we, ls_we, le_we, pos_we, k1_we, k2_we, pl_we, pr_we;
   logic [11:0] ctrl_wd;
   logic [16:0] step_wd;
   logic [30:0] ls_wd, le_wd, pos_wd;
   logic [11:0] k1_wd, k2_wd;
   logic [7:0]  pl_wd, pr_wd;

   // Read port of the voice arrays.
   logic [4:0]    av;
   logic          av_ok;
   logic [VW-1:0] av_idx;
   logic [11:0]   ctrl_rd;
   logic [16:0]   step_rd;
   logic [30:0]   ls_rd, le_rd, pos_rd;
   logic [11:0]   k1_rd, k2_rd;
   logic [7:0]    pl_rd, pr_rd;

   // Shared multiplier.
   logic [31:0] mul_a, mul_p;
   logic [15:0] mul_b;

   // Misc combinational values.
   logic        req_acc, rsp_load;
   logic [7:0]  base8;
   logic [PAW-1:0] vbase;
   logic [1:0]  bm;
   logic [11:0] c_new;
   logic [30:0] a_new;
   logic [31:0] x_sum;

   assign req_acc  = req_if.valid && req_if.ready;
   assign rsp_load = (state_ff == wve_pkg::ST_FIN) && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = (state_ff == wve_pkg::ST_IDLE);

   // Voice selected for the array read port.
   always_comb begin
      case (state_ff)
         wve_pkg::ST_REG_A, wve_pkg::ST_REG_B: av = page_ff[4:0];
         wve_pkg::ST_FIN:                      av = turn_ff;
         default:                              av = cur_vi_ff;
      endcase
   end
   assign av_ok  = ({1'b0, av} < NV);
   assign av_idx = av_ok ? av[VW-1:0] : '0;
   assign ctrl_rd = ctrl_ff[av_idx];
   assign step_rd = step_ff[av_idx];
   assign ls_rd   = ls_ff[av_idx];
   assign le_rd   = le_ff[av_idx];
   assign pos_rd  = pos_ff[av_idx];
   assign k1_rd   = k1_ff[av_idx];
   assign k2_rd   = k2_ff[av_idx];
   assign pl_rd   = pl_ff[av_idx];
   assign pr_rd   = pr_ff[av_idx];

   // Base address of the selected voice's six poles.
   assign base8   = {1'b0, av, 2'b00} + {2'b00, av, 1'b0};
   assign vbase   = PAW'(base8);
   assign pole_rd = pvq_ff ? ram_q : 32'd0;

   assign mul_p = mul_a * {16'd0, mul_b};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wve_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = (req_if.req_type == wve_pkg::REQ_STEP) ?
                          wve_pkg::ST_INTERP0 : wve_pkg::ST_REG_A;
            end
         end
         wve_pkg::ST_REG_A:    state_in = wve_pkg::ST_REG_B;
         wve_pkg::ST_REG_B:    state_in = wve_pkg::ST_FIN;
         wve_pkg::ST_INTERP0: begin
            state_in = (!av_ok || (ctrl_rd[1:0] != 2'd0)) ?
                       wve_pkg::ST_FIN : wve_pkg::ST_INTERP1;
         end
         wve_pkg::ST_INTERP1:  state_in = wve_pkg::ST_LP1_MUL;
         wve_pkg::ST_LP1_MUL:  state_in = wve_pkg::ST_LP1_ADD;
         wve_pkg::ST_LP1_ADD:  state_in = wve_pkg::ST_LP2_MUL;
         wve_pkg::ST_LP2_MUL:  state_in = wve_pkg::ST_LP2_ADD;
         wve_pkg::ST_LP2_ADD:  state_in = wve_pkg::ST_P3_MUL;
         wve_pkg::ST_P3_MUL:   state_in = wve_pkg::ST_P3_ADD;
         wve_pkg::ST_P3_ADD:   state_in = wve_pkg::ST_P4_MUL;
         wve_pkg::ST_P4_MUL:   state_in = wve_pkg::ST_P4_ADD;
         wve_pkg::ST_P4_ADD:   state_in = wve_pkg::ST_VOL_L;
         wve_pkg::ST_VOL_L:    state_in = wve_pkg::ST_VOL_R;
         wve_pkg::ST_VOL_R:    state_in = wve_pkg::ST_ADVANCE;
         wve_pkg::ST_ADVANCE:  state_in = wve_pkg::ST_LOOP_CHK;
         wve_pkg::ST_LOOP_CHK: state_in = wve_pkg::ST_LOOP_FIX;
         wve_pkg::ST_LOOP_FIX: state_in = wve_pkg::ST_FIN;
         wve_pkg::ST_FIN: begin
            if (rsp_load) begin
               state_in = wve_pkg::ST_IDLE;
            end
         end
         default:              state_in = wve_pkg::ST_IDLE;
      endcase
   end

   // Datapath and register updates for each state.
   always_comb begin
      active_in = active_ff;  irq_pend_in = irq_pend_ff;  irqv_in = irqv_ff;
      page_in = page_ff;  mode_in = mode_ff;  turn_in = turn_ff;
      rq_type_in = rq_type_ff;  rq_reg_in = rq_reg_ff;  rq_wv_in = rq_wv_ff;
      smp0_in = smp0_ff;  smp1_in = smp1_ff;  pins_in = pins_ff;  cur_vi_in = cur_vi_ff;
      prod_in = prod_ff;  x_in = x_ff;  st0_in = st0_ff;  st1_in = st1_ff;
      st3_in = st3_ff;  st5_in = st5_ff;  left_in = left_ff;  right_in = right_ff;
      a_in = a_ff;  d_in = d_ff;  exceed_in = exceed_ff;  stop_in = stop_ff;
      fend_in = fend_ff;  bus_in = bus_ff;  rd_in = rd_ff;
      ctrl_we = 1'b0;  step_we = 1'b0;  ls_we = 1'b0;  le_we = 1'b0;  pos_we = 1'b0;
      k1_we = 1'b0;  k2_we = 1'b0;  pl_we = 1'b0;  pr_we = 1'b0;
      ctrl_wd = ctrl_rd;  step_wd = step_rd;  ls_wd = ls_rd;  le_wd = le_rd;
      pos_wd = pos_rd;  k1_wd = k1_rd;  k2_wd = k2_rd;  pl_wd = pl_rd;  pr_wd = pr_rd;
      ram_we = 1'b0;  ram_waddr = vbase;  ram_wdata = x_in;  ram_raddr = '0;
      mul_a = 32'd0;  mul_b = 16'd0;
      bm = ctrl_rd[9:8];
      c_new = ctrl_rd;
      a_new = a_ff;
      x_sum = 32'd0;

      case (state_ff)
         // Latch the item and clear the result fields.
         wve_pkg::ST_IDLE: begin
            if (req_acc) begin
               rq_type_in = req_if.req_type;
               rq_reg_in  = req_if.reg_req;
               rq_wv_in   = req_if.write_value;
               smp0_in    = req_if.first_sample;
               smp1_in    = req_if.second_sample;
               pins_in    = req_if.port_pins;
               cur_vi_in  = turn_ff;
               rd_in = 16'd0;  left_in = 32'd0;  right_in = 32'd0;
               bus_in = 2'd0;  stop_in = 1'b0;  fend_in = 1'b0;
            end
         end

         // Fetch the pole behind a pole-page register.
         wve_pkg::ST_REG_A: begin
            if (av_ok) begin
               ram_raddr = vbase + PAW'(wve_pkg::pole_slot(rq_reg_ff));
            end
         end

         // Register read or write.
         wve_pkg::ST_REG_B: begin
            ram_waddr = vbase + PAW'(wve_pkg::pole_slot(rq_reg_ff));
            ram_wdata = {{16{rq_wv_ff[15]}}, rq_wv_ff};
            if (rq_type_ff == wve_pkg::REQ_READ) begin
               if (rq_reg_ff == wve_pkg::REG_ACTIVE) begin
                  rd_in = {11'd0, active_ff};
               end else if (rq_reg_ff == wve_pkg::REG_IRQV) begin
                  rd_in = irq_pend_ff ? {11'd0, irqv_ff} : wve_pkg::IRQ_IDLE;
                  irq_pend_in = 1'b0;
               end else if (rq_reg_ff == wve_pkg::REG_PAGE) begin
                  rd_in = {9'd0, page_ff};
               end else if (page_ff[6]) begin
                  if (rq_reg_ff == wve_pkg::REG_MODE) begin
                     rd_in = {mode_ff[7:3], 8'hff, mode_ff[2:0]};
                  end else if (rq_reg_ff == wve_pkg::REG_PORT) begin
                     rd_in = {pins_ff, 6'd0};
                  end
               end else if (!av_ok) begin
                  rd_in = 16'd0;
               end else if (rq_reg_ff == wve_pkg::REG_CTRL) begin
                  rd_in = {4'hf, ctrl_rd};
               end else if (page_ff[5]) begin
                  if (rq_reg_ff >= wve_pkg::REG_STEP && rq_reg_ff <= wve_pkg::REG_K2) begin
                     rd_in = pole_rd[15:0];
                  end
               end else begin
                  case (rq_reg_ff)
                     wve_pkg::REG_STEP:   rd_in = step_rd[16:1];
                     wve_pkg::REG_LS_HI:  rd_in = {3'd0, ls_rd[30:18]};
                     wve_pkg::REG_LS_LO:  rd_in = ls_rd[17:2];
                     wve_pkg::REG_LE_HI:  rd_in = {3'd0, le_rd[30:18]};
                     wve_pkg::REG_LE_LO:  rd_in = le_rd[17:2];
                     wve_pkg::REG_K2:     rd_in = {k2_rd, 4'd0};
                     wve_pkg::REG_K1:     rd_in = {k1_rd, 4'd0};
                     wve_pkg::REG_PAN_L:  rd_in = {pl_rd, 8'd0};
                     wve_pkg::REG_PAN_R:  rd_in = {pr_rd, 8'd0};
                     wve_pkg::REG_POS_HI: rd_in = {3'd0, pos_rd[30:18]};
                     wve_pkg::REG_POS_LO: rd_in = pos_rd[17:2];
                     default:             rd_in = 16'd0;
                  endcase
               end
            end else if (rq_type_ff == wve_pkg::REQ_WRITE) begin
               if (rq_reg_ff == wve_pkg::REG_ACTIVE) begin
                  active_in = rq_wv_ff[4:0];
               end else if (rq_reg_ff == wve_pkg::REG_PAGE) begin
                  page_in = rq_wv_ff[6:0];
               end else if (rq_reg_ff == wve_pkg::REG_IRQV) begin
                  page_in = page_ff;
               end else if (page_ff[6]) begin
                  if (rq_reg_ff == wve_pkg::REG_MODE) begin
                     mode_in = {rq_wv_ff[15:11], rq_wv_ff[2:0]};
                  end
               end else if (av_ok) begin
                  if (rq_reg_ff == wve_pkg::REG_CTRL) begin
                     ctrl_we = 1'b1;
                     ctrl_wd = rq_wv_ff[11:0];
                  end else if (page_ff[5]) begin
                     ram_we = (rq_reg_ff >= wve_pkg::REG_STEP) &&
                              (rq_reg_ff <= wve_pkg::REG_K2);
                  end else begin
                     case (rq_reg_ff)
                        wve_pkg::REG_STEP: begin
                           step_we = 1'b1;
                           step_wd = {rq_wv_ff[15:1], 2'b00};
                        end
                        wve_pkg::REG_LS_HI: begin
                           ls_we = 1'b1;  ls_wd = {rq_wv_ff[12:0], ls_rd[17:0]};
                        end
                        wve_pkg::REG_LS_LO: begin
                           ls_we = 1'b1;  ls_wd = {ls_rd[30:18], rq_wv_ff[15:5], 7'd0};
                        end
                        wve_pkg::REG_LE_HI: begin
                           le_we = 1'b1;  le_wd = {rq_wv_ff[12:0], le_rd[17:0]};
                        end
                        wve_pkg::REG_LE_LO: begin
                           le_we = 1'b1;  le_wd = {le_rd[30:18], rq_wv_ff[15:5], 7'd0};
                        end
                        wve_pkg::REG_K2: begin
                           k2_we = 1'b1;  k2_wd = rq_wv_ff[15:4];
                        end
                        wve_pkg::REG_K1: begin
                           k1_we = 1'b1;  k1_wd = rq_wv_ff[15:4];
                        end
                        wve_pkg::REG_PAN_L: begin
                           pl_we = 1'b1;  pl_wd = rq_wv_ff[15:8];
                        end
                        wve_pkg::REG_PAN_R: begin
                           pr_we = 1'b1;  pr_wd = rq_wv_ff[15:8];
                        end
                        wve_pkg::REG_POS_HI: begin
                           pos_we = 1'b1;  pos_wd = {rq_wv_ff[12:0], pos_rd[17:0]};
                        end
                        wve_pkg::REG_POS_LO: begin
                           pos_we = 1'b1;  pos_wd = {pos_rd[30:18], rq_wv_ff, 2'b00};
                        end
                        default: begin
                           pos_we = 1'b0;
                        end
                     endcase
                  end
               end
            end
         end

         // First interpolation product, or a stopped voice that only advances the turn.
         wve_pkg::ST_INTERP0: begin
            for (int i = 0; i < 3; i++) begin
               if ({1'b0, bm} >= 3'(BUS_PAIRS)) begin
                  bm = bm - 2'(BUS_PAIRS);
               end
            end
            if (!av_ok || (ctrl_rd[1:0] != 2'd0)) begin
               stop_in = 1'b1;
               if (cur_vi_ff >= active_ff) begin
                  turn_in = 5'd0;  fend_in = 1'b1;
               end else begin
                  turn_in = cur_vi_ff + 5'd1;
               end
            end else begin
               bus_in    = bm;
               ram_raddr = vbase + PAW'(wve_pkg::PS_P1);
               mul_a     = {{16{smp0_ff[15]}}, smp0_ff};
               mul_b     = {4'd0, 12'd2048 - {1'b0, pos_rd[10:0]}};
               prod_in   = mul_p;
            end
         end

         // Second interpolation product and the weighted sum.
         wve_pkg::ST_INTERP1: begin
            st0_in    = pole_rd;
            ram_raddr = vbase + PAW'(wve_pkg::PS_P2);
            mul_a     = {{16{smp1_ff[15]}}, smp1_ff};
            mul_b     = {5'd0, pos_rd[10:0]};
            x_sum     = prod_ff + mul_p;
            x_in      = 32'($signed(x_sum) >>> 11);
         end

         // First low-pass pole.
         wve_pkg::ST_LP1_MUL: begin
            st1_in    = pole_rd;
            ram_raddr = vbase + PAW'(wve_pkg::PS_P3);
            mul_a     = x_ff - st0_ff;
            mul_b     = {4'd0, k1_rd};
            prod_in   = mul_p;
         end
         wve_pkg::ST_LP1_ADD: begin
            st3_in    = pole_rd;
            ram_raddr = vbase + PAW'(wve_pkg::PS_P4);
            x_in      = wve_pkg::div_4096(prod_ff) + st0_ff;
            ram_we    = 1'b1;
            ram_waddr = vbase + PAW'(wve_pkg::PS_P1);
            ram_wdata = x_in;
         end

         // Second low-pass pole.
         wve_pkg::ST_LP2_MUL: begin
            st5_in  = pole_rd;
            mul_a   = x_ff - st1_ff;
            mul_b   = {4'd0, k1_rd};
            prod_in = mul_p;
         end
         wve_pkg::ST_LP2_ADD: begin
            x_in      = wve_pkg::div_4096(prod_ff) + st1_ff;
            ram_we    = 1'b1;
            ram_waddr = vbase + PAW'(wve_pkg::PS_P2);
            ram_wdata = x_in;
         end

         // Third pole: high-pass in mode 0, low-pass on k2 in mode 2, else on k1.
         wve_pkg::ST_P3_MUL: begin
            case (ctrl_rd[11:10])
               2'd0: begin
                  mul_a = st3_ff;  mul_b = {4'd0, k2_rd};
               end
               2'd2: begin
                  mul_a = x_ff - st3_ff;  mul_b = {4'd0, k2_rd};
               end
               default: begin
                  mul_a = x_ff - st3_ff;  mul_b = {4'd0, k1_rd};
               end
            endcase
            prod_in   = mul_p;
            ram_we    = 1'b1;
            ram_waddr = vbase + PAW'(wve_pkg::PS_P2Q);
            ram_wdata = st1_ff;
         end
         wve_pkg::ST_P3_ADD: begin
            if (ctrl_rd[11:10] == 2'd0) begin
               x_in = x_ff - st1_ff + wve_pkg::div_8192(prod_ff) + wve_pkg::half(st3_ff);
            end else begin
               x_in = wve_pkg::div_4096(prod_ff) + st3_ff;
            end
            ram_we    = 1'b1;
            ram_waddr = vbase + PAW'(wve_pkg::PS_P3);
            ram_wdata = x_in;
         end

         // Fourth pole: high-pass in modes 0 and 1, low-pass on k2 otherwise.
         wve_pkg::ST_P4_MUL: begin
            mul_a     = ctrl_rd[11] ? (x_ff - st5_ff) : st5_ff;
            mul_b     = {4'd0, k2_rd};
            prod_in   = mul_p;
            ram_we    = 1'b1;
            ram_waddr = vbase + PAW'(wve_pkg::PS_P3Q);
            ram_wdata = st3_ff;
         end
         wve_pkg::ST_P4_ADD: begin
            if (!ctrl_rd[11]) begin
               x_in = x_ff - st3_ff + wve_pkg::div_8192(prod_ff) + wve_pkg::half(st5_ff);
            end else begin
               x_in = wve_pkg::div_4096(prod_ff) + st5_ff;
            end
            ram_we    = 1'b1;
            ram_waddr = vbase + PAW'(wve_pkg::PS_P4);
            ram_wdata = x_in;
         end

         // Volume scaling for left then right.
         wve_pkg::ST_VOL_L: begin
            mul_a   = x_ff;
            mul_b   = wve_pkg::vol_of(pl_rd);
            prod_in = mul_p;
         end
         wve_pkg::ST_VOL_R: begin
            left_in = 32'($signed(prod_ff) >>> 11);
            mul_a   = x_ff;
            mul_b   = wve_pkg::vol_of(pr_rd);
            prod_in = mul_p;
         end

         // Step the position forward or backward.
         wve_pkg::ST_ADVANCE: begin
            right_in = 32'($signed(prod_ff) >>> 11);
            a_in = ctrl_rd[6] ? (pos_rd - {14'd0, step_rd}) : (pos_rd + {14'd0, step_rd});
         end

         // Test the loop bound and measure the overshoot.
         wve_pkg::ST_LOOP_CHK: begin
            if (ctrl_rd[6]) begin
               exceed_in = (a_ff < ls_rd);
               d_in      = ls_rd - a_ff;
            end else begin
               exceed_in = (a_ff > le_rd);
               d_in      = a_ff - le_rd;
            end
         end

         // Apply loop, bidirectional or stop rules, the interrupt and the turn.
         wve_pkg::ST_LOOP_FIX: begin
            if (exceed_ff) begin
               if (ctrl_rd[5]) begin
                  c_new[7] = 1'b1;
               end
               if (ctrl_rd[4:3] == 2'b01) begin
                  a_new = ctrl_rd[6] ? (le_rd - d_ff) : (ls_rd + d_ff);
               end else if (ctrl_rd[4:3] == 2'b11) begin
                  a_new    = ctrl_rd[6] ? (ls_rd + d_ff) : (le_rd - d_ff);
                  c_new[6] = ~ctrl_rd[6];
               end else begin
                  c_new[0] = 1'b1;
               end
            end
            if (c_new[7] && !irq_pend_ff) begin
               irq_pend_in = 1'b1;
               irqv_in     = cur_vi_ff;
               c_new[7]    = 1'b0;
            end
            pos_we  = 1'b1;  pos_wd  = a_new;
            ctrl_we = 1'b1;  ctrl_wd = c_new;
            if (cur_vi_ff >= active_ff) begin
               turn_in = 5'd0;  fend_in = 1'b1;
            end else begin
               turn_in = cur_vi_ff + 5'd1;
            end
         end

         default: begin
            rd_in = rd_ff;
         end
      endcase
   end

   // Control and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wve_pkg::ST_IDLE;
         active_ff   <= 5'd31;
         irq_pend_ff <= 1'b0;
         page_ff     <= 7'd0;
         mode_ff     <= 8'd0;
         turn_ff     <= 5'd0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         irq_pend_ff <= irq_pend_in;
         page_ff     <= page_in;
         mode_ff     <= mode_in;
         turn_ff     <= turn_in;
      end
      irqv_ff <= irqv_in;  rq_type_ff <= rq_type_in;  rq_reg_ff <= rq_reg_in;
      rq_wv_ff <= rq_wv_in;  smp0_ff <= smp0_in;  smp1_ff <= smp1_in;
      pins_ff <= pins_in;  cur_vi_ff <= cur_vi_in;  prod_ff <= prod_in;  x_ff <= x_in;
      st0_ff <= st0_in;  st1_ff <= st1_in;  st3_ff <= st3_in;  st5_ff <= st5_in;
      left_ff <= left_in;  right_ff <= right_in;  a_ff <= a_in;  d_ff <= d_in;
      exceed_ff <= exceed_in;  stop_ff <= stop_in;  fend_ff <= fend_in;
      bus_ff <= bus_in;  rd_ff <= rd_in;
   end

   // Voice register arrays, one write port at the selected voice.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            ctrl_ff[i] <= 12'h003;  step_ff[i] <= 17'd0;  ls_ff[i] <= 31'd0;
            le_ff[i] <= 31'd0;  pos_ff[i] <= 31'd0;  k1_ff[i] <= 12'd0;
            k2_ff[i] <= 12'd0;  pl_ff[i] <= 8'd128;  pr_ff[i] <= 8'd128;
         end
      end else begin
         if (ctrl_we) ctrl_ff[av_idx] <= ctrl_wd;
         if (step_we) step_ff[av_idx] <= step_wd;
         if (ls_we)   ls_ff[av_idx]   <= ls_wd;
         if (le_we)   le_ff[av_idx]   <= le_wd;
         if (pos_we)  pos_ff[av_idx]  <= pos_wd;
         if (k1_we)   k1_ff[av_idx]   <= k1_wd;
         if (k2_we)   k2_ff[av_idx]   <= k2_wd;
         if (pl_we)   pl_ff[av_idx]   <= pl_wd;
         if (pr_we)   pr_ff[av_idx]   <= pr_wd;
      end
   end

   // Pole valid bits; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (ram_we) begin
         pv_ff[ram_waddr] <= 1'b1;
      end
      pvq_ff <= pv_ff[ram_raddr];
   end

   wve_ram #(.WIDTH(32), .DEPTH(POLES)) u_pole_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_q)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         o_rd_ff    <= rd_ff;
         o_vi_ff    <= (rq_type_ff == wve_pkg::REQ_STEP) ? cur_vi_ff : 5'd0;
         o_bus_ff   <= bus_ff;
         o_left_ff  <= left_ff;
         o_right_ff <= right_ff;
         o_fa_ff    <= av_ok ? pos_rd[30:11] : 20'd0;
         o_fb_ff    <= av_ok ? ctrl_rd[2] : 1'b0;
         o_stop_ff  <= stop_ff;
         o_fend_ff  <= fend_ff;
         o_irq_ff   <= irq_pend_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.read_data     = o_rd_ff;
   assign rsp_if.voice_index   = o_vi_ff;
   assign rsp_if.bus           = o_bus_ff;
   assign rsp_if.left_part     = o_left_ff;
   assign rsp_if.right_part    = o_right_ff;
   assign rsp_if.fetch_address = o_fa_ff;
   assign rsp_if.fetch_bank    = o_fb_ff;
   assign rsp_if.voice_stopped = o_stop_ff;
   assign rsp_if.frame_end     = o_fend_ff;
   assign rsp_if.irq_pending   = o_irq_ff;

   // The engine is not ready in the cycle after it takes an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_if.ready) else $error("ready right after an accepted item");

   // A stopped voice contributes nothing.
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.voice_stopped) |->
      (rsp_if.left_part == 32'd0 && rsp_if.right_part == 32'd0))
      else $error("stopped voice has a contribution");

   // The turn wraps to voice zero at the end of a frame.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && fend_ff) |-> (turn_ff == 5'd0)) else $error("frame end without wrap");

   // The interrupt vector is only claimed by the loop stage of a voice step.
   a_irq_source: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_pend_ff) |-> ($past(state_ff) == wve_pkg::ST_LOOP_FIX))
      else $error("interrupt vector set outside the loop stage");
endmodule

/* hdl/wve_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the filter pole store.
module wve_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 192
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* bench/tb.sv */
// Self-checking bench for the wavetable voice engine: directed register and voice-step items,
// then random traffic, checked against a predictor of the paged voice registers and datapath.
// Depends on wve_pkg, wve_req_if, wve_rsp_if and the wavetable_voice_engine RTL.
`timescale 1ns / 100ps

module tb;
   import wve_pkg::*;

   // Control word bits.
   localparam logic [15:0] CTL_STOP   = 16'h0003;
   localparam logic [15:0] CTL_BANK   = 16'h0004;
   localparam logic [15:0] CTL_LOOP   = 16'h0008;
   localparam logic [15:0] CTL_BIDIR  = 16'h0010;
   localparam logic [15:0] CTL_IRQE   = 16'h0020;
   localparam logic [15:0] CTL_REV    = 16'h0040;
   localparam logic [15:0] CTL_IRQ    = 16'h0080;
   localparam logic [15:0] CTL_FORCED = 16'hf000;
   localparam logic [3:0]  REG_UNUSED = 4'd12;
   localparam logic [31:0] POS_MASK   = 32'h7fffffff;
   localparam int NVOICE       = 32;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      req_kind_type       kind;
      logic [3:0]         r;
      logic [15:0]        wv;
      logic signed [15:0] s0;
      logic signed [15:0] s1;
      logic [9:0]         pins;
      logic               typed;
      logic [15:0]        rd;
   } req_row_t;

   typedef struct packed {
      logic [15:0]        read_data;
      logic [4:0]         voice_index;
      logic [1:0]         bus;
      logic signed [31:0] left_part;
      logic signed [31:0] right_part;
      logic [19:0]        fetch_address;
      logic               fetch_bank;
      logic               voice_stopped;
      logic               frame_end;
      logic               irq_pending;
   } voice_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wve_req_if req ();
   wve_rsp_if rsp ();

   wavetable_voice_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req.sink),
      .rsp_if (rsp.source)
   );

   always #1 clock = ~clock;

   // Predicted engine state.
   logic [15:0] m_ctrl   [NVOICE];
   logic [31:0] m_step   [NVOICE];
   logic [31:0] m_lstart [NVOICE];
   logic [31:0] m_lend   [NVOICE];
   logic [31:0] m_pos    [NVOICE];
   logic [15:0] m_k1     [NVOICE];
   logic [15:0] m_k2     [NVOICE];
   logic [7:0]  m_panl   [NVOICE];
   logic [7:0]  m_panr   [NVOICE];
   int          m_pole   [NVOICE*6];
   logic [4:0]  m_active;
   logic [7:0]  m_irqv;
   logic [6:0]  m_page;
   logic [15:0] m_mode;
   logic [4:0]  m_turn;

   voice_result_t   expected_results[$];
   req_row_t        issued_rows[$];
   int mismatches = 0;
   int checked = 0;
   int steps_played = 0, steps_stopped = 0, frames = 0, irqs_taken = 0;
   int cycles = 0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   function automatic void reset_model();
      for (int i = 0; i < NVOICE; i++) begin
         m_ctrl[i] = 16'hf003;
         m_step[i] = '0;
         m_lstart[i] = '0;
         m_lend[i] = '0;
         m_pos[i] = '0;
         m_k1[i] = '0;
         m_k2[i] = '0;
         m_panl[i] = 8'd128;
         m_panr[i] = 8'd128;
      end
      for (int i = 0; i < NVOICE*6; i++) m_pole[i] = 0;
      m_active = 5'd31;
      m_irqv = 8'h80;
      m_page = '0;
      m_mode = '0;
      m_turn = '0;
   endfunction

   // One low-pass pole: st + k*(x-st)/4096, truncating toward zero.
   function automatic int low_pole(int x, logic [15:0] k, int st);
      int p;
      p = int'({20'd0, k[15:4]}) * (x - st);
      return p / 4096 + st;
   endfunction

   // One high-pass pole built from the previous input and current state.
   function automatic int high_pole(int x, logic [15:0] k, int st, int prev);
      int p;
      p = int'({20'd0, k[15:4]}) * st;
      return x - prev + p / 8192 + st / 2;
   endfunction

   function automatic int volume(logic [7:0] v);
      logic [31:0] m;
      m = {27'd0, 1'b1, v[3:0]} << 11;
      return int'(m >> (16 - v[7:4]));
   endfunction

   // Four-pole filter chain of one voice, updating its poles.
   function automatic int filter_chain(int vi, int x);
      int b;
      logic [1:0] fmode;
      b = vi * 6;
      fmode = m_ctrl[vi][11:10];
      x = low_pole(x, m_k1[vi], m_pole[b+0]);
      m_pole[b+0] = x;
      x = low_pole(x, m_k1[vi], m_pole[b+1]);
      m_pole[b+2] = m_pole[b+1];
      m_pole[b+1] = x;
      if (fmode == 2'd0) x = high_pole(x, m_k2[vi], m_pole[b+3], m_pole[b+2]);
      else if (fmode == 2'd2) x = low_pole(x, m_k2[vi], m_pole[b+3]);
      else x = low_pole(x, m_k1[vi], m_pole[b+3]);
      m_pole[b+4] = m_pole[b+3];
      m_pole[b+3] = x;
      if (fmode < 2'd2) x = high_pole(x, m_k2[vi], m_pole[b+5], m_pole[b+4]);
      else x = low_pole(x, m_k2[vi], m_pole[b+5]);
      m_pole[b+5] = x;
      return x;
   endfunction

   // Loop, bidirectional and stop handling once the position passes a bound.
   function automatic void loop_rules(int vi);
      logic [15:0] c;
      logic [15:0] lp;
      logic [31:0] a, s, e;
      c = m_ctrl[vi];
      lp = c & (CTL_LOOP | CTL_BIDIR);
      a = m_pos[vi];
      s = m_lstart[vi];
      e = m_lend[vi];
      if ((c & CTL_REV) == 0) begin
         if (a <= e) return;
         if (c & CTL_IRQE) c |= CTL_IRQ;
         if (lp == CTL_LOOP) a = (s + a - e) & POS_MASK;
         else if (lp == (CTL_LOOP | CTL_BIDIR)) begin
            a = (e - (a - e)) & POS_MASK;
            c ^= CTL_REV;
         end else c |= 16'h0001;
      end else begin
         if (a >= s) return;
         if (c & CTL_IRQE) c |= CTL_IRQ;
         if (lp == CTL_LOOP) a = (e - (s - a)) & POS_MASK;
         else if (lp == (CTL_LOOP | CTL_BIDIR)) begin
            a = (s + (s - a)) & POS_MASK;
            c ^= CTL_REV;
         end else c |= 16'h0001;
      end
      m_pos[vi] = a;
      m_ctrl[vi] = c;
   endfunction

   function automatic int pole_index(logic [3:0] r);
      case (r)
         REG_STEP:  return 5;
         REG_LS_HI: return 3;
         REG_LS_LO: return 4;
         REG_LE_HI: return 1;
         REG_LE_LO: return 2;
         default:   return 0;
      endcase
   endfunction

   function automatic logic [15:0] read_register(logic [3:0] r, logic [9:0] pins);
      int vi;
      logic [15:0] v;
      vi = m_page[4:0];
      if (r == REG_ACTIVE) return {11'd0, m_active};
      if (r == REG_IRQV) begin
         v = {8'd0, m_irqv};
         m_irqv = 8'h80;
         return v;
      end
      if (r == REG_PAGE) return {9'd0, m_page};
      if (m_page >= 7'h40) begin
         if (r == REG_MODE) return m_mode | 16'h07f8;
         if (r == REG_PORT) return {pins, 6'd0};
         return '0;
      end
      if (r == REG_CTRL) return m_ctrl[vi] | CTL_FORCED;
      if (m_page >= 7'h20) begin
         if (r >= REG_STEP && r <= REG_K2) return m_pole[vi*6 + pole_index(r)][15:0];
         return '0;
      end
      case (r)
         REG_STEP:   return m_step[vi][16:1];
         REG_LS_HI:  return {3'd0, m_lstart[vi][30:18]};
         REG_LS_LO:  return m_lstart[vi][17:2];
         REG_LE_HI:  return {3'd0, m_lend[vi][30:18]};
         REG_LE_LO:  return m_lend[vi][17:2];
         REG_K2:     return m_k2[vi];
         REG_K1:     return m_k1[vi];
         REG_PAN_L:  return {m_panl[vi], 8'd0};
         REG_PAN_R:  return {m_panr[vi], 8'd0};
         REG_POS_HI: return {3'd0, m_pos[vi][30:18]};
         REG_POS_LO: return m_pos[vi][17:2];
         default:    return '0;
      endcase
   endfunction

   function automatic void write_register(logic [3:0] r, logic [15:0] v);
      int vi;
      vi = m_page[4:0];
      if (r == REG_ACTIVE) begin
         m_active = v[4:0];
         return;
      end
      if (r == REG_PAGE) begin
         m_page = v[6:0];
         return;
      end
      if (r == REG_IRQV) return;
      if (m_page >= 7'h40) begin
         if (r == REG_MODE) m_mode = (m_mode & 16'h07f8) | (v & 16'hf807);
         return;
      end
      if (r == REG_CTRL) begin
         m_ctrl[vi] = v | CTL_FORCED;
         return;
      end
      if (m_page >= 7'h20) begin
         if (r >= REG_STEP && r <= REG_K2) m_pole[vi*6 + pole_index(r)] = int'(signed'(v));
         return;
      end
      case (r)
         REG_STEP:   m_step[vi] = {15'd0, v & 16'hfffe, 1'b0};
         REG_LS_HI:  m_lstart[vi][30:18] = v[12:0];
         REG_LS_LO:  m_lstart[vi][17:0] = {v & 16'hffe0, 2'd0};
         REG_LE_HI:  m_lend[vi][30:18] = v[12:0];
         REG_LE_LO:  m_lend[vi][17:0] = {v & 16'hffe0, 2'd0};
         REG_K2:     m_k2[vi] = v & 16'hfff0;
         REG_K1:     m_k1[vi] = v & 16'hfff0;
         REG_PAN_L:  m_panl[vi] = v[15:8];
         REG_PAN_R:  m_panr[vi] = v[15:8];
         REG_POS_HI: m_pos[vi][30:18] = v[12:0];
         REG_POS_LO: m_pos[vi][17:0] = {v, 2'd0};
         default: ;
      endcase
   endfunction

   // Result of one request item, advancing the predicted state.
   function automatic voice_result_t engine_result(req_row_t it);
      voice_result_t res;
      int vi, fr, x;
      logic [15:0] c;
      res = '0;
      case (it.kind)
         REQ_READ:  res.read_data = read_register(it.r, it.pins);
         REQ_WRITE: write_register(it.r, it.wv);
         REQ_STEP: begin
            vi = m_turn;
            res.voice_index = m_turn;
            if (m_ctrl[vi] & CTL_STOP) begin
               res.voice_stopped = 1'b1;
               steps_stopped++;
            end else begin
               steps_played++;
               c = m_ctrl[vi];
               fr = int'({21'd0, m_pos[vi][10:0]});
               x = (int'(it.s0) * (2048 - fr) + int'(it.s1) * fr) >>> 11;
               x = filter_chain(vi, x);
               res.bus = c[9:8];
               res.left_part = (x * volume(m_panl[vi])) >>> 11;
               res.right_part = (x * volume(m_panr[vi])) >>> 11;
               if (c & CTL_REV) m_pos[vi] = (m_pos[vi] - m_step[vi]) & POS_MASK;
               else m_pos[vi] = (m_pos[vi] + m_step[vi]) & POS_MASK;
               loop_rules(vi);
               if ((m_ctrl[vi] & CTL_IRQ) && m_irqv[7]) begin
                  m_irqv = vi[7:0];
                  m_ctrl[vi] &= ~CTL_IRQ;
                  irqs_taken++;
               end
            end
            if (m_turn >= m_active) begin
               m_turn = '0;
               res.frame_end = 1'b1;
               frames++;
            end else m_turn = m_turn + 5'd1;
         end
         default: ;
      endcase
      res.fetch_address = m_pos[m_turn][30:11];
      res.fetch_bank = m_ctrl[m_turn][2];
      res.irq_pending = ~m_irqv[7];
      if (it.typed) res.read_data = it.rd;
      return res;
   endfunction

   // Record the expectation of every accepted request item.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         expected_results.push_back(engine_result(issued_rows.pop_front()));
      end
   end

   // Compare every accepted result item with the oldest expectation.
   always @(posedge clock) begin
      voice_result_t got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.read_data, rsp.voice_index, rsp.bus, rsp.left_part, rsp.right_part,
                 rsp.fetch_address, rsp.fetch_bank, rsp.voice_stopped, rsp.frame_end,
                 rsp.irq_pending};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item: %p", got);
         end else begin
            want = expected_results.pop_front();
            checked++;
            if (got.read_data !== want.read_data || got.voice_index !== want.voice_index ||
                got.bus !== want.bus || got.left_part !== want.left_part ||
                got.right_part !== want.right_part ||
                got.fetch_address !== want.fetch_address ||
                got.fetch_bank !== want.fetch_bank ||
                got.voice_stopped !== want.voice_stopped ||
                got.frame_end !== want.frame_end || got.irq_pending !== want.irq_pending) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on result %0d", checked);
                  $display("  expected %p", want);
                  $display("  actual   %p", got);
               end
            end
         end
      end
   end

   // Result side: random stalls, one long hold-off, and a steady stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp.ready <= 1'b0;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         rsp.ready <= steady || ($urandom_range(99) >= 20);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycles,
                  expected_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offer one item and wait for it to be taken.
   task automatic offer(req_row_t it);
      while (!steady && $urandom_range(99) < 20) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= it.kind;
      req.reg_req <= it.r;
      req.write_value <= it.wv;
      req.first_sample <= it.s0;
      req.second_sample <= it.s1;
      req.port_pins <= it.pins;
      issued_rows.push_back(it);
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Random item: half are voice steps, and control writes mostly clear the stop bits.
   function automatic req_row_t random_row();
      req_row_t it;
      int pick;
      it = '0;
      it.s0 = $urandom;
      it.s1 = $urandom;
      it.pins = $urandom;
      it.wv = $urandom;
      it.r = $urandom_range(0, 15);
      pick = $urandom_range(99);
      if (pick < 50) it.kind = REQ_STEP;
      else if (pick < 58) it.kind = REQ_FETCH;
      else if (pick < 70) it.kind = REQ_READ;
      else begin
         it.kind = REQ_WRITE;
         pick = $urandom_range(99);
         if (it.r == REG_PAGE) begin
            if (pick < 80) it.wv = $urandom_range(0, 31);
            else if (pick < 90) it.wv = $urandom_range(32, 63);
            else if (pick < 95) it.wv = $urandom_range(64, 127);
         end else if (it.r == REG_CTRL) begin
            if (pick < 85) it.wv &= ~CTL_STOP;
         end else if (it.r == REG_ACTIVE && pick < 70) begin
            it.r = REG_K1;
         end
      end
      return it;
   endfunction

   initial begin
      req_row_t rows[$];
      req.valid = 1'b0;
      req.req_type = REQ_READ;
      req.reg_req = '0;
      req.write_value = '0;
      req.first_sample = '0;
      req.second_sample = '0;
      req.port_pins = '0;
      reset_model();

      // Reset values, unused and ignored registers, the global page, the pole page.
      rows.push_back('{REQ_READ,  REG_ACTIVE, 16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'd31});
      rows.push_back('{REQ_READ,  REG_IRQV,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h0080});
      rows.push_back('{REQ_READ,  REG_PAGE,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h0000});
      rows.push_back('{REQ_READ,  REG_CTRL,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'hf003});
      rows.push_back('{REQ_READ,  REG_PAN_L,  16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h8000});
      rows.push_back('{REQ_READ,  REG_UNUSED, 16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h0000});
      rows.push_back('{REQ_WRITE, REG_IRQV,   16'hffff, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_READ,  REG_IRQV,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h0080});
      rows.push_back('{REQ_WRITE, REG_PAGE,   16'h0040, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_READ,  REG_MODE,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h07f8});
      rows.push_back('{REQ_READ,  REG_PORT,   16'h0, 16'sh0, 16'sh0, 10'h3ff, 1'b1, 16'hffc0});
      rows.push_back('{REQ_WRITE, REG_MODE,   16'hffff, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_READ,  REG_MODE,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'hffff});
      rows.push_back('{REQ_READ,  REG_CTRL,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h0000});
      rows.push_back('{REQ_WRITE, REG_PAGE,   16'h0020, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_WRITE, REG_STEP,   16'h8000, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_READ,  REG_STEP,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b1, 16'h8000});
      // Voice 0 playing with full cutoffs, fastest step and a tiny bidirectional loop.
      rows.push_back('{REQ_WRITE, REG_PAGE,   16'h0000, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_WRITE, REG_K1,     16'hffff, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_WRITE, REG_K2,     16'hffff, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_WRITE, REG_STEP,   16'hffff, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_WRITE, REG_LE_LO,  16'h0020, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_WRITE, REG_CTRL,   16'h0038, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_STEP,  REG_CTRL,   16'h0, 16'sh7fff, -16'sh8000, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_STEP,  REG_CTRL,   16'h0, -16'sh8000, 16'sh7fff, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_FETCH, REG_CTRL,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});
      rows.push_back('{REQ_READ,  REG_IRQV,   16'h0, 16'sh0, 16'sh0, 10'h0, 1'b0, 16'h0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) offer(rows[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400) hold_request <= 1'b1;
         if (n == 700) steady <= 1'b1;
         if (n == 1000) steady <= 1'b0;
         if (n == 1200) begin
            req.valid <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0) @(posedge clock);
         end
         offer(random_row());
      end
      req.valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("checked %0d results: %0d playing steps, %0d stopped steps, %0d frames,",
               checked, steps_played, steps_stopped, frames);
      $display("%0d interrupts latched, %0d mismatches", irqs_taken, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/wve_pkg.sv
hdl/wve_req_if.sv
hdl/wve_rsp_if.sv
hdl/wve_ram.sv
hdl/wavetable_voice_engine.sv
bench/tb.sv
